>>> sv/euler_totient_core_macros.svh
// assertion macros shared by the euler totient checker
`ifndef EULER_TOTIENT_CORE_MACROS_SVH
`define EULER_TOTIENT_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define ETC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("euler totient assertion failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define ETC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("euler totient assertion failed");

`endif

>>> sv/etc_pkg.sv
// shared types and constants of the euler totient core
package etc_pkg;

   localparam int DEFAULT_WIDTH   = 32;
   localparam int FIRST_CANDIDATE = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_STRIP,
      ST_REDUCE,
      ST_LAST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
   } div_stat_type;

endpackage

>>> sv/etc_div.sv
// shared restoring divider, one quotient bit per cycle
module etc_div #(
   parameter int WIDTH = etc_pkg::DEFAULT_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  etc_pkg::div_ctrl_type ctrl,
   input  logic [WIDTH-1:0]     dividend,
   input  logic [WIDTH-1:0]     divisor,
   output etc_pkg::div_stat_type stat,
   output logic [WIDTH-1:0]     quotient,
   output logic [WIDTH-1:0]     remainder
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             last_step;

   always_comb begin
      trial     = {rem_ff, quo_ff[WIDTH-1]};
      diff      = trial - {1'b0, dvs_ff};
      last_step = busy_ff && (cnt_ff == CW'(1));
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = last_step;
      if (ctrl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // borrow out of the trial subtract means the divisor did not fit
         if (diff[WIDTH]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end else begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end
         cnt_in = cnt_ff - CW'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> sv/euler_totient_core.sv
// euler totient core: trial division sequencer around one shared divider
// divisions: one per candidate, one more per factor divided out and per reduction of the result
// worst case is a prime near 2^WIDTH: about 2^(WIDTH/2) divisions
// a new number is taken only once the result of the last one is in the output register,
//   which waits on rsp_stall while it still holds an earlier result
// reset: synchronous, clears the sequencer and the result valid flag, data registers keep
//   their contents
module euler_totient_core #(
   parameter int WIDTH = etc_pkg::DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [WIDTH-1:0] req_number_in,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [WIDTH-1:0] rsp_totient
);

   // sequencer state and working values
   etc_pkg::state_type state_ff, state_in;
   logic [WIDTH-1:0]   x_ff, x_in;       // working copy, factors stripped as found
   logic [WIDTH-1:0]   r_ff, r_in;       // running totient
   logic [WIDTH-1:0]   i_ff, i_in;       // current trial candidate

   // output register, decouples the result transfer from the sequencer
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]   rsp_totient_ff, rsp_totient_in;

   // shared divider interface
   etc_pkg::div_ctrl_type div_ctrl;
   etc_pkg::div_stat_type div_stat;
   logic [WIDTH-1:0]      div_a;
   logic [WIDTH-1:0]      div_b;
   logic [WIDTH-1:0]      div_q;
   logic [WIDTH-1:0]      div_rem;

   etc_div #(
      .WIDTH (WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (div_a),
      .divisor   (div_b),
      .stat      (div_stat),
      .quotient  (div_q),
      .remainder (div_rem)
   );

   always_comb begin
      state_in       = state_ff;
      x_in           = x_ff;
      r_in           = r_ff;
      i_in           = i_ff;
      div_ctrl.start = 1'b0;
      div_a          = x_ff;
      div_b          = i_ff;
      // a pending result drops once its transfer completes
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_totient_in = rsp_totient_ff;

      unique case (state_ff)
         etc_pkg::ST_IDLE: begin
            // take a new number and kick off x / 2
            if (req_valid) begin
               x_in           = req_number_in;
               r_in           = req_number_in;
               i_in           = WIDTH'(etc_pkg::FIRST_CANDIDATE);
               div_ctrl.start = 1'b1;
               div_a          = req_number_in;
               div_b          = WIDTH'(etc_pkg::FIRST_CANDIDATE);
               state_in       = etc_pkg::ST_TEST;
            end
         end
         etc_pkg::ST_TEST: begin
            // x / i done: loop bound check, then divisibility
            if (div_stat.done) begin
               if (i_ff > div_q) begin
                  // candidates exhausted, leftover x above one is a last prime
                  if (x_ff > WIDTH'(1)) begin
                     div_ctrl.start = 1'b1;
                     div_a          = r_ff;
                     div_b          = x_ff;
                     state_in       = etc_pkg::ST_LAST;
                  end else begin
                     state_in = etc_pkg::ST_EMIT;
                  end
               end else if (div_rem == '0) begin
                  x_in           = div_q;
                  div_ctrl.start = 1'b1;
                  div_a          = div_q;
                  div_b          = i_ff;
                  state_in       = etc_pkg::ST_STRIP;
               end else begin
                  i_in           = i_ff + WIDTH'(1);
                  div_ctrl.start = 1'b1;
                  div_a          = x_ff;
                  div_b          = i_ff + WIDTH'(1);
               end
            end
         end
         etc_pkg::ST_STRIP: begin
            // keep dividing out i, then reduce the result by r / i
            if (div_stat.done) begin
               div_ctrl.start = 1'b1;
               if (div_rem == '0) begin
                  x_in  = div_q;
                  div_a = div_q;
                  div_b = i_ff;
               end else begin
                  div_a    = r_ff;
                  div_b    = i_ff;
                  state_in = etc_pkg::ST_REDUCE;
               end
            end
         end
         etc_pkg::ST_REDUCE: begin
            // r -= r / i, move on to the next candidate
            if (div_stat.done) begin
               r_in           = r_ff - div_q;
               i_in           = i_ff + WIDTH'(1);
               div_ctrl.start = 1'b1;
               div_a          = x_ff;
               div_b          = i_ff + WIDTH'(1);
               state_in       = etc_pkg::ST_TEST;
            end
         end
         etc_pkg::ST_LAST: begin
            // r -= r / x for the last prime
            if (div_stat.done) begin
               r_in     = r_ff - div_q;
               state_in = etc_pkg::ST_EMIT;
            end
         end
         etc_pkg::ST_EMIT: begin
            // load the output register once it is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_totient_in = r_ff;
               state_in       = etc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = etc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= etc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      r_ff           <= r_in;
      i_ff           <= i_in;
      rsp_totient_ff <= rsp_totient_in;
   end

   // a new number is taken only while the sequencer is idle
   assign req_stall   = (state_ff != etc_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_totient = rsp_totient_ff;

endmodule

>>> sv/etc_checker.sv
// port-level checker for the euler totient core, with its bind
`include "euler_totient_core_macros.svh"

module etc_checker #(
   parameter int WIDTH = etc_pkg::DEFAULT_WIDTH
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic [WIDTH-1:0] req_number_in,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [WIDTH-1:0] rsp_totient
);

   // an accepted number keeps the core busy on the following cycle
   `ETC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // a stalled number stays offered and unchanged
   `ETC_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_number_in))

   // a fresh result appears only as the sequencer returns to idle
   `ETC_ASSERT_SAME(a_result_with_idle, $rose(rsp_valid), !req_stall)

   // a stalled result stays valid and unchanged
   `ETC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_totient))

endmodule

bind euler_totient_core etc_checker #(
   .WIDTH (WIDTH)
) u_etc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_number_in (req_number_in),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_totient   (rsp_totient)
);
